FILE: design/lfu_pkg.sv
// shared types and constants for the lfu cache
package lfu_pkg;
    localparam int unsigned CAPACITY   = 16;
    localparam int unsigned COUNT_BITS = 16;
    localparam int unsigned IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned RANK_BITS  = IDX_BITS;
    localparam int unsigned OCC_BITS   = $clog2(CAPACITY + 1);
    localparam int unsigned CAP_BITS   = 5;
    localparam int unsigned KEY_BITS   = 32;
    localparam int unsigned VAL_BITS   = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture incoming word
        logic scan_clear;  // reset scan pointer and search results
        logic scan_step;   // examine one entry
        logic touch;       // touch the found entry (value write on put)
        logic evict;       // drop the chosen victim
        logic insert;      // insert new key at free slot
        logic out_load;    // load result register
    } lfu_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_put;
        logic scan_last;
        logic found;
        logic over_full;   // occupancy >= effective capacity
        logic cap_zero;
    } lfu_sts_t;
endpackage

FILE: design/lfu_datapath.sv
// lfu datapath: entry storage, serial scan, touch, evict and insert
module lfu_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfu_pkg::lfu_cmd_t             cmd,
    output lfu_pkg::lfu_sts_t             sts,
    input  logic                          cfg_we,
    input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_data,
    input  logic                          in_op,
    input  logic [lfu_pkg::KEY_BITS-1:0]  in_key,
    input  logic [lfu_pkg::VAL_BITS-1:0]  in_val,
    output logic                          res_hit,
    output logic [lfu_pkg::VAL_BITS-1:0]  res_val
);
    import lfu_pkg::*;

    logic [CAP_BITS-1:0]   cap_reg;
    logic [CAPACITY-1:0]   valid_reg;
    logic [KEY_BITS-1:0]   key_reg   [CAPACITY];
    logic [VAL_BITS-1:0]   value_reg [CAPACITY];
    logic [COUNT_BITS-1:0] cnt_reg   [CAPACITY];
    logic [RANK_BITS-1:0]  rank_reg  [CAPACITY];

    logic                  op_reg;
    logic [KEY_BITS-1:0]   wkey_reg;
    logic [VAL_BITS-1:0]   wval_reg;
    logic [IDX_BITS-1:0]   ptr_reg;
    logic                  found_reg;
    logic [IDX_BITS-1:0]   hit_idx_reg;
    logic                  vic_ok_reg;
    logic [IDX_BITS-1:0]   vic_idx_reg;
    logic                  free_ok_reg;
    logic [IDX_BITS-1:0]   free_idx_reg;
    logic [OCC_BITS-1:0]   occ_reg;

    logic [OCC_BITS-1:0]   eff_cap;
    logic                  better;
    logic [RANK_BITS-1:0]  t_rank;
    logic [RANK_BITS-1:0]  v_rank;

    // effective capacity clipped to storage
    always_comb
    begin
        if (32'(cap_reg) > CAPACITY)
            eff_cap = OCC_BITS'(CAPACITY);
        else
            eff_cap = OCC_BITS'(cap_reg);
    end

    // victim compare for the entry under the scan pointer
    always_comb
    begin
        better = !vic_ok_reg ||
                 (cnt_reg[ptr_reg] < cnt_reg[vic_idx_reg]) ||
                 ((cnt_reg[ptr_reg] == cnt_reg[vic_idx_reg]) &&
                  (rank_reg[ptr_reg] > rank_reg[vic_idx_reg]));
        t_rank = rank_reg[hit_idx_reg];
        v_rank = rank_reg[vic_idx_reg];
    end

    assign sts.is_put    = op_reg;
    assign sts.scan_last = (32'(ptr_reg) == CAPACITY - 1);
    assign sts.found     = found_reg;
    assign sts.over_full = (occ_reg >= eff_cap);
    assign sts.cap_zero  = (eff_cap == '0);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_BITS'(16);
            valid_reg <= '0;
            occ_reg   <= '0;
            ptr_reg   <= '0;
            found_reg <= 1'b0;
            vic_ok_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            res_hit   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (cmd.scan_clear)
            begin
                ptr_reg     <= '0;
                found_reg   <= 1'b0;
                vic_ok_reg  <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                ptr_reg <= ptr_reg + 1'b1;
                if (valid_reg[ptr_reg])
                begin
                    if (!found_reg && key_reg[ptr_reg] == wkey_reg)
                        found_reg <= 1'b1;
                    if (better)
                        vic_ok_reg <= 1'b1;
                end
                else if (!free_ok_reg)
                    free_ok_reg <= 1'b1;
            end
            if (cmd.evict && vic_ok_reg)
            begin
                valid_reg[vic_idx_reg] <= 1'b0;
                occ_reg <= occ_reg - 1'b1;
            end
            if (cmd.insert && free_ok_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                occ_reg <= occ_reg + 1'b1;
            end
            if (cmd.out_load)
                res_hit <= found_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            wkey_reg <= in_key;
            wval_reg <= in_val;
        end
        if (cmd.scan_step)
        begin
            if (valid_reg[ptr_reg])
            begin
                if (!found_reg && key_reg[ptr_reg] == wkey_reg)
                    hit_idx_reg <= ptr_reg;
                if (better)
                    vic_idx_reg <= ptr_reg;
            end
            else if (!free_ok_reg)
                free_idx_reg <= ptr_reg;
        end
        if (cmd.out_load)
            res_val <= found_reg ? value_reg[hit_idx_reg] : '0;
        // rank and count updates, one operation per cycle across all entries
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cmd.touch)
            begin
                if (IDX_BITS'(i) == hit_idx_reg)
                begin
                    rank_reg[i] <= '0;
                    if (cnt_reg[i] != COUNT_MAX)
                        cnt_reg[i] <= cnt_reg[i] + 1'b1;
                    if (op_reg)
                        value_reg[i] <= wval_reg;
                end
                else if (valid_reg[i] && rank_reg[i] < t_rank)
                    rank_reg[i] <= rank_reg[i] + 1'b1;
            end
            if (cmd.evict && vic_ok_reg && valid_reg[i] && rank_reg[i] > v_rank)
                rank_reg[i] <= rank_reg[i] - 1'b1;
            if (cmd.insert && free_ok_reg)
            begin
                if (IDX_BITS'(i) == free_idx_reg)
                begin
                    key_reg[i]   <= wkey_reg;
                    value_reg[i] <= wval_reg;
                    cnt_reg[i]   <= COUNT_BITS'(1);
                    rank_reg[i]  <= '0;
                end
                else if (valid_reg[i])
                    rank_reg[i] <= rank_reg[i] + 1'b1;
            end
        end
    end
endmodule

FILE: design/lfu_ctrl.sv
// lfu controller state machine
module lfu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output lfu_pkg::lfu_cmd_t  cmd,
    input  lfu_pkg::lfu_sts_t  sts
);
    import lfu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_EVICT = 6'b001000,
        S_INS   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign in_stall  = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign out_valid = ov_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (!sts.is_put)
                begin
                    cmd.out_load = 1'b1;
                    cmd.touch    = sts.found;
                    state_next   = S_DONE;
                end
                else if (sts.cap_zero)
                    state_next = S_IDLE;
                else if (sts.found)
                begin
                    cmd.touch  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.over_full)
                begin
                    cmd.evict  = 1'b1;
                    state_next = S_EVICT;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EVICT:
            begin
                // rescan for the next victim and the free slot
                cmd.scan_clear = 1'b1;
                state_next     = S_INS;
            end
            S_INS:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_DEC;
            end
            S_DONE:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

FILE: design/lfu_cache_with_lru_tiebreak_core.sv
// top level of the lfu cache with lru tie-break
// Fully associative 16-entry key/value cache. Each word is handled by a serial
// scan of all entries, one entry a cycle, for key match, lowest-count/oldest
// victim and first free slot. A get then loads the result register and touches
// a hit; a put that hits touches the entry, a put with room inserts, and a put
// of a new key to a full cache evicts the victim and scans again per eviction.
// A get result sits in an output register and the next word waits while it is
// stalled; one word is worked on at a time.
module lfu_cache_with_lru_tiebreak_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [lfu_pkg::KEY_BITS-1:0]  lookup_key,
    input  logic [lfu_pkg::VAL_BITS-1:0]  write_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [lfu_pkg::VAL_BITS-1:0]  read_value
);
    import lfu_pkg::*;

    lfu_cmd_t cmd;
    lfu_sts_t sts;

    lfu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
    );

    lfu_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_op(operation), .in_key(lookup_key), .in_val(write_value),
        .res_hit(hit), .res_val(read_value)
    );
endmodule

FILE: design/lfu_checker.sv
// port-level checker for the lfu cache, bound to the top level
module lfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        operation,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [31:0] read_value
);
    // a miss returns zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (read_value == '0))
        else $error("miss with nonzero value");
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_value) && $stable(hit)))
        else $error("stalled result changed");
    // an accepted word is followed by a busy cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted two words back to back");
    // a put yields no result shortly after
    a_put: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation && !out_valid) |=> !out_valid)
        else $error("result from a put");
endmodule

bind lfu_cache_with_lru_tiebreak_core lfu_checker u_lfu_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .read_value(read_value)
);

FILE: test/tb.sv
// testbench for the lfu cache with lru tie-break
`timescale 1ns / 1ps

module tb;
    import lfu_pkg::*;

    localparam int N_ENT = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CAP_BITS-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                operation;
    logic [KEY_BITS-1:0] lookup_key;
    logic [VAL_BITS-1:0] write_value;
    logic                out_valid;
    logic                out_stall;
    logic                hit;
    logic [VAL_BITS-1:0] read_value;

    typedef struct packed {
        logic                hit;
        logic [VAL_BITS-1:0] value;
    } lookup_t;

    // cache shadow
    logic [CAP_BITS-1:0]   shadow_cap;
    logic                  sh_valid [N_ENT];
    logic [KEY_BITS-1:0]   sh_key [N_ENT];
    logic [VAL_BITS-1:0]   sh_value [N_ENT];
    logic [COUNT_BITS-1:0] sh_count [N_ENT];
    logic [RANK_BITS-1:0]  sh_rank [N_ENT];

    lookup_t pending_lookups [$];
    int      errors;
    int      gets_seen;
    int      hits_seen;
    int      puts_sent;
    longint  cycles;
    int      key_pool;

    lfu_cache_with_lru_tiebreak_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .lookup_key(lookup_key), .write_value(write_value),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
        .read_value(read_value)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL lfu_cache_with_lru_tiebreak_core");
            $finish;
        end
    end

    function automatic int find_entry(logic [KEY_BITS-1:0] k);
        for (int i = 0; i < N_ENT; i++)
            if (sh_valid[i] && sh_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int used_slots();
        int n;
        n = 0;
        for (int i = 0; i < N_ENT; i++)
            if (sh_valid[i])
                n++;
        return n;
    endfunction

    // bump an entry to most recent and raise its count
    task automatic mark_used(int e);
        logic [RANK_BITS-1:0] r;
        r = sh_rank[e];
        for (int i = 0; i < N_ENT; i++)
            if (sh_valid[i] && i != e && sh_rank[i] < r)
                sh_rank[i] = sh_rank[i] + 1'b1;
        sh_rank[e] = '0;
        if (sh_count[e] != COUNT_MAX)
            sh_count[e] = sh_count[e] + 1'b1;
    endtask

    // drop lowest count, oldest among equals
    task automatic drop_victim();
        int v;
        v = -1;
        for (int i = 0; i < N_ENT; i++)
        begin
            if (!sh_valid[i])
                continue;
            if (v < 0 || sh_count[i] < sh_count[v] ||
                (sh_count[i] == sh_count[v] && sh_rank[i] > sh_rank[v]))
                v = i;
        end
        if (v < 0)
            return;
        for (int i = 0; i < N_ENT; i++)
            if (sh_valid[i] && sh_rank[i] > sh_rank[v])
                sh_rank[i] = sh_rank[i] - 1'b1;
        sh_valid[v] = 1'b0;
    endtask

    // work out the effect of one word, queueing a lookup result on a get
    task automatic predict_word(logic op, logic [KEY_BITS-1:0] k, logic [VAL_BITS-1:0] v);
        int e;
        int lim;
        int slot;
        lookup_t res;
        e = find_entry(k);
        lim = (shadow_cap > N_ENT) ? N_ENT : int'(shadow_cap);
        if (op == OP_GET)
        begin
            res.hit = (e >= 0);
            res.value = (e >= 0) ? sh_value[e] : '0;
            if (e >= 0)
                mark_used(e);
            pending_lookups.push_back(res);
            return;
        end
        if (lim == 0)
            return;
        if (e >= 0)
        begin
            sh_value[e] = v;
            mark_used(e);
            return;
        end
        while (used_slots() >= lim)
            drop_victim();
        slot = -1;
        for (int i = 0; i < N_ENT; i++)
        begin
            if (!sh_valid[i])
            begin
                if (slot < 0)
                    slot = i;
            end
            else
                sh_rank[i] = sh_rank[i] + 1'b1;
        end
        if (slot < 0)
            return;
        sh_valid[slot] = 1'b1;
        sh_key[slot] = k;
        sh_value[slot] = v;
        sh_count[slot] = COUNT_BITS'(1);
        sh_rank[slot] = '0;
    endtask

    // send one word after a random gap
    task automatic send_word(logic op, logic [KEY_BITS-1:0] k, logic [VAL_BITS-1:0] v,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        lookup_key  <= k;
        write_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(op, k, v);
        if (op == OP_PUT)
            puts_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        // a put may still be evicting or inserting
        repeat (400) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] c);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_cap = c;
        @(posedge clk);
    endtask

    // result stall and checking
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_lookups.size() == 0)
                begin
                    $error("lookup result with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    gets_seen++;
                    if (hit)
                        hits_seen++;
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d got %0d", want.hit, hit);
                        errors++;
                    end
                    if (read_value !== want.value)
                    begin
                        $error("read_value: expected %h got %h", want.value, read_value);
                        errors++;
                    end
                end
            end
        end
    end

    int stall_left;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (out_valid && !out_stall && ($urandom_range(0, 2) != 0))
        begin
            stall_left <= $urandom_range(0, 17);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [KEY_BITS-1:0] pick_key();
        return (32'h1000 + $urandom_range(0, key_pool - 1));
    endfunction

    task automatic test_extremes();
        send_word(OP_GET, 32'h0, 32'h0);
        send_word(OP_PUT, 32'h0, 32'hFFFF_FFFF);
        send_word(OP_PUT, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_GET, 32'h0, 32'h0);
        send_word(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_PUT, 32'h0, 32'hA5A5_5A5A);
        send_word(OP_GET, 32'h0, 32'h0);
        send_word(OP_GET, 32'h1234_5678, 32'h0);
    endtask

    // fill, then force lfu and lru-tie evictions
    task automatic test_eviction();
        write_capacity(5'd3);
        send_word(OP_PUT, 32'h10, 32'h100);
        send_word(OP_PUT, 32'h11, 32'h110);
        send_word(OP_PUT, 32'h12, 32'h120);
        send_word(OP_GET, 32'h10, 32'h0);
        send_word(OP_PUT, 32'h13, 32'h130);
        send_word(OP_GET, 32'h11, 32'h0);
        send_word(OP_GET, 32'h12, 32'h0);
        send_word(OP_GET, 32'h13, 32'h0);
    endtask

    // zero capacity, oversize capacity, and lowering below occupancy
    task automatic test_capacity_edges();
        write_capacity(5'd0);
        send_word(OP_PUT, 32'h10, 32'hDEAD);
        send_word(OP_PUT, 32'h77, 32'h77);
        send_word(OP_GET, 32'h10, 32'h0);
        send_word(OP_GET, 32'h77, 32'h0);
        write_capacity(5'd31);
        for (int i = 0; i < 18; i++)
            send_word(OP_PUT, 32'h200 + i, $urandom, 1);
        send_word(OP_GET, 32'h200, 32'h0);
        write_capacity(5'd2);
        send_word(OP_GET, 32'h210, 32'h0);
        send_word(OP_PUT, 32'h300, 32'h3);
        send_word(OP_GET, 32'h300, 32'h0);
        write_capacity(5'd1);
        send_word(OP_PUT, 32'h301, 32'h4);
        send_word(OP_GET, 32'h301, 32'h0);
    endtask

    task automatic test_random(int n);
        logic [CAP_BITS-1:0] caps [6] = '{5'd16, 5'd1, 5'd4, 5'd8, 5'd0, 5'd20};
        int op_roll;
        for (int p = 0; p < 6; p++)
        begin
            write_capacity(caps[p]);
            key_pool = (p % 2 == 0) ? 24 : 10;
            for (int i = 0; i < n / 6; i++)
            begin
                op_roll = $urandom_range(0, 9);
                if (op_roll == 0)
                    send_word(1'($urandom_range(0, 1)), $urandom, $urandom);
                else
                    send_word(op_roll < 5 ? OP_PUT : OP_GET, pick_key(), $urandom);
                // hold until all lookups are back
                if (i == n / 12)
                    drain();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_GET;
        lookup_key = '0;
        write_value = '0;
        out_stall = 1'b0;
        stall_left = 0;
        cycles = 0;
        errors = 0;
        gets_seen = 0;
        hits_seen = 0;
        puts_sent = 0;
        key_pool = 16;
        shadow_cap = 5'd16;
        for (int i = 0; i < N_ENT; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_key[i] = '0;
            sh_value[i] = '0;
            sh_count[i] = '0;
            sh_rank[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_eviction();
        test_capacity_edges();
        test_random(540);

        drain();
        $display("covered %0d lookups (%0d hits) and %0d stores over capacities 0..31",
                 gets_seen, hits_seen, puts_sent);
        if (errors == 0 && pending_lookups.size() == 0)
            $display("PASS lfu_cache_with_lru_tiebreak_core");
        else
            $display("FAIL lfu_cache_with_lru_tiebreak_core");
        $finish;
    end
endmodule

FILE: sim.f
design/lfu_pkg.sv
design/lfu_datapath.sv
design/lfu_ctrl.sv
design/lfu_cache_with_lru_tiebreak_core.sv
design/lfu_checker.sv
test/tb.sv
